### rtl/sorted_list_engine_assert.svh
// ----------------------------------------------------------------------------
// sorted_list_engine_assert.svh
// Assertion macros shared by the sorted list engine RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared sizes, codes and types of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [IDX_W-1:0]       idx_t;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_READ     = 3'd2,
        REQ_CONTAINS = 3'd3,
        REQ_COUNT    = 3'd4,
        REQ_CLEAR    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic rotate;   // shift toward cell 0, wrap at the end
        logic ins;      // open a slot and drop the operand in
        logic rem;      // close the slot at the first match
    } cell_ctl_t;

endpackage

### rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, compares it to the operand and moves data
// to or from its neighbors.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  value_t    v,
    input  logic      valid,
    input  value_t    prev_entry,
    input  logic      prev_lt,
    input  value_t    next_entry,
    output value_t    entry,
    output logic      lt
);

    value_t entry_reg;

    assign entry = entry_reg;
    assign lt    = valid && (entry_reg < v);

    always_ff @(posedge clk)
    begin
        if (ctl.rotate)
        begin
            entry_reg <= next_entry;
        end
        else if (ctl.ins && !lt)
        begin
            // first slot not below the operand takes it, the rest shift up
            entry_reg <= prev_lt ? v : prev_entry;
        end
        else if (ctl.rem && !lt)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule

### rtl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Ascending list of values with duplicates, kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_type, value, index) is taken on a rising edge
//   with start high and busy low. busy stays high until the result is out.
//   Each result is on status/read_value/found/match_count/occupancy for
//   exactly one cycle while done is high; the receiver cannot stall, so the
//   result is gone after that cycle.
// Sequence (accept edge to the cycle done is high):
//   insert, clear, unused codes: from idle straight to the update state.
//   remove, read, contains, count: a scan state first; the list rotates
//   once through the whole chain past cell 0, where one value comparator
//   gathers match and count and the entry at the requested index is read;
//   rotating all DEPTH cells puts every entry back in its slot before the update.
// Requests do not overlap: the next start can be taken at the
//   rising edge that ends the cycle in which done is high.
// Insert and remove update all cells at once in the update state: each
//   cell compares its entry to the operand and takes data from a neighbor.
// Reset: the list is empty (occupancy zero), busy and done are low. Cell
//   contents are not reset; slots at or above the fill count are never read.
// ----------------------------------------------------------------------------
`include "sorted_list_engine_assert.svh"

module sorted_list_engine
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  value_t     value,
    input  idx_t       index,
    output logic       done,
    output logic [1:0] status,
    output value_t     read_value,
    output logic       found,
    output cnt_t       match_count,
    output cnt_t       occupancy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT
    } state_t;

    state_t    state_reg;
    req_t      op_reg;
    value_t    v_reg;
    idx_t      idx_reg;
    idx_t      scan_reg;
    cnt_t      fill_reg;
    logic      hit_reg;
    cnt_t      cnt_reg;
    value_t    rd_reg;
    logic      rd_hit_reg;

    logic      done_reg;
    status_t   status_reg;
    value_t    read_value_reg;
    logic      found_reg;
    cnt_t      match_reg;

    value_t    cell_val [DEPTH];
    logic      cell_lt  [DEPTH];
    logic      cell_valid [DEPTH];
    cell_ctl_t ctl;

    logic      accept;
    logic      head_valid;
    logic      head_eq;
    logic      list_full;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign head_valid = ({1'b0, scan_reg} < fill_reg);
    assign head_eq    = head_valid && (cell_val[0] == v_reg);
    assign list_full  = (fill_reg == CNT_W'(DEPTH));

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign match_count = match_reg;
    assign occupancy   = fill_reg;

    // Cell commands.
    always_comb
    begin
        ctl        = '0;
        ctl.rotate = (state_reg == S_SCAN);
        if (state_reg == S_ACT)
        begin
            ctl.ins = (op_reg == REQ_INSERT) && !list_full;
            ctl.rem = (op_reg == REQ_REMOVE) && hit_reg;
        end
    end

    // Chain of cells; cell 0 sees a "below" sentinel on its lower side.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        value_t prev_entry;
        logic   prev_lt;

        if (i == 0)
        begin : g_head
            assign prev_entry = cell_val[0];
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_body
            assign prev_entry = cell_val[i-1];
            assign prev_lt    = cell_lt[i-1];
        end

        assign cell_valid[i] = (CNT_W'(i) < fill_reg);

        sle_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .v          (v_reg),
            .valid      (cell_valid[i]),
            .prev_entry (prev_entry),
            .prev_lt    (prev_lt),
            .next_entry (cell_val[(i + 1) % DEPTH]),
            .entry      (cell_val[i]),
            .lt         (cell_lt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
            op_reg         <= REQ_INSERT;
            v_reg          <= '0;
            idx_reg        <= '0;
            scan_reg       <= '0;
            hit_reg        <= 1'b0;
            cnt_reg        <= '0;
            rd_reg         <= '0;
            rd_hit_reg     <= 1'b0;
            status_reg     <= ST_OK;
            read_value_reg <= '0;
            found_reg      <= 1'b0;
            match_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= req_t'(req_type);
                        v_reg      <= value;
                        idx_reg    <= index;
                        scan_reg   <= '0;
                        hit_reg    <= 1'b0;
                        cnt_reg    <= '0;
                        rd_reg     <= '0;
                        rd_hit_reg <= 1'b0;
                        if (req_type inside {REQ_REMOVE, REQ_READ, REQ_CONTAINS, REQ_COUNT})
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_ACT;
                        end
                    end
                end

                S_SCAN:
                begin
                    // cell 0 holds the entry at position scan_reg
                    if (head_eq)
                    begin
                        hit_reg <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (head_valid && (scan_reg == idx_reg))
                    begin
                        rd_reg     <= cell_val[0];
                        rd_hit_reg <= 1'b1;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_reg <= S_ACT;
                    end
                end

                S_ACT:
                begin
                    status_reg     <= ST_OK;
                    read_value_reg <= '0;
                    found_reg      <= 1'b0;
                    match_reg      <= '0;
                    case (op_reg)
                        REQ_INSERT:
                        begin
                            if (list_full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                fill_reg <= fill_reg - 1'b1;
                            end
                            else
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                        end
                        REQ_READ:
                        begin
                            if (rd_hit_reg)
                            begin
                                read_value_reg <= rd_reg;
                            end
                            else
                            begin
                                status_reg <= ST_RANGE;
                            end
                        end
                        REQ_CONTAINS:
                        begin
                            found_reg <= hit_reg;
                        end
                        REQ_COUNT:
                        begin
                            match_reg <= cnt_reg;
                        end
                        REQ_CLEAR:
                        begin
                            fill_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SLE_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")
    `SLE_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SLE_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted request not in progress")
    `SLE_ASSERT_NEXT(a_insert_grow, ctl.ins, fill_reg == $past(fill_reg) + 1'b1, "no growth")

endmodule

### tb/sv/sorted_list_checker.sv
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches the request and result channels of the sorted list engine, keeps
// a shadow copy of the ordered list and checks every result transaction
// field by field against the predicted one, in order of issue.
// ----------------------------------------------------------------------------
module sorted_list_checker
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] req_type,
    input  value_t     value,
    input  idx_t       index,
    input  logic       done,
    input  logic [1:0] status,
    input  value_t     read_value,
    input  logic       found,
    input  cnt_t       match_count,
    input  cnt_t       occupancy,
    output int         fail_count,
    output int         pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t status;
        value_t  read_value;
        logic    found;
        cnt_t    match_count;
        cnt_t    occupancy;
    } list_resp_t;

    value_t     shadow_list [DEPTH];
    int         shadow_len;
    list_resp_t expected_resps [$];

    // Applies one request to the shadow list and returns the result it gives.
    function automatic list_resp_t apply_request(logic [2:0] code, value_t val, idx_t idx);
        list_resp_t r;
        int         pos;
        int         i;
        r.status      = ST_OK;
        r.read_value  = '0;
        r.found       = 1'b0;
        r.match_count = '0;
        // first slot whose entry is not below the operand
        pos = shadow_len;
        for (i = 0; i < shadow_len; i++)
        begin
            if (shadow_list[i] >= val)
            begin
                pos = i;
                break;
            end
        end
        case (code)
            REQ_INSERT:
            begin
                if (shadow_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            end
            REQ_REMOVE:
            begin
                if (pos < shadow_len && shadow_list[pos] == val)
                begin
                    for (i = pos; i < shadow_len - 1; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            REQ_READ:
            begin
                if (int'(idx) < shadow_len)
                    r.read_value = shadow_list[idx];
                else
                    r.status = ST_RANGE;
            end
            REQ_CONTAINS:
                r.found = (pos < shadow_len && shadow_list[pos] == val);
            REQ_COUNT:
            begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_list[i] == val)
                        r.match_count++;
            end
            REQ_CLEAR:
                shadow_len = 0;
            default: ;  // unused codes leave the list alone
        endcase
        r.occupancy = cnt_t'(shadow_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_resp_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_resps.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_resps.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result with nothing outstanding: status=%0d occ=%0d",
                                 $realtime, status, occupancy);
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (status !== want.status || read_value !== want.read_value ||
                        found !== want.found || match_count !== want.match_count ||
                        occupancy !== want.occupancy)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] mismatch: exp status=%0d rd=%h found=%0d ",
                                     $realtime, want.status, want.read_value, want.found,
                                     "cnt=%0d occ=%0d, got status=%0d rd=%h found=%0d ",
                                     want.match_count, want.occupancy, status, read_value,
                                     found, "cnt=%0d occ=%0d", match_count, occupancy);
                    end
                end
            end
            if (start && !busy)
                expected_resps.insert(expected_resps.size(),
                                      apply_request(req_type, value, index));
        end
        pending = expected_resps.size();
    end

endmodule

### tb/sv/sorted_list_engine_test.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_test
// Drives request transactions into the sorted list engine and gives the
// verdict. A short directed sequence covers empty-list queries, value
// extremes, duplicates, range errors and unused codes; a random part then
// cycles through fill, mixed and drain phases so the list reaches full and
// empty repeatedly. Checking is done by sorted_list_checker.
// ----------------------------------------------------------------------------
module sorted_list_engine_test
    import sle_pkg::*;
();

    // Request codes the package leaves unnamed; the block must ignore them.
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam int NUM_RANDOM  = 1880;
    localparam int QUIET_TAIL  = 200;     // last transactions sent with no gaps
    localparam int PHASE_LEN   = 120;
    localparam int POOL_SIZE   = 6;
    // Slowest run: ~1900 queries, each a full scan plus an idle gap,
    // taken several times over.
    localparam int CYCLE_LIMIT = 750000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] req_type;
    value_t     value;
    idx_t       index;
    logic       done;
    logic [1:0] status;
    value_t     read_value;
    logic       found;
    cnt_t       match_count;
    cnt_t       occupancy;

    int         fail_count;
    int         pending;
    int         cycle_count;

    value_t     value_pool [POOL_SIZE];

    sorted_list_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .found       (found),
        .match_count (match_count),
        .occupancy   (occupancy)
    );

    sorted_list_checker list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .found       (found),
        .match_count (match_count),
        .occupancy   (occupancy),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Presents one request transaction at the falling edge and holds it until
    // a rising edge sees busy low. busy only moves on rising edges, so its
    // value at a falling edge is the one the next rising edge sees. start
    // stays high after the accept edge; the next call or idle burst decides
    // its value at the next falling edge.
    task automatic issue_request(input logic [2:0] code, input value_t val, input idx_t idx);
        @(negedge clk);
        start    <= 1'b1;
        req_type <= code;
        value    <= val;
        index    <= idx;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drops start for the idle gap given by n; the payload carries junk meanwhile so that
    // the block is seen to ignore it.
    task automatic idle_burst(input int n);
        @(negedge clk);
        start    <= 1'b0;
        req_type <= 3'($urandom);
        value    <= value_t'($urandom);
        index    <= idx_t'($urandom);
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Mostly values from a small pool so removes, contains and counts hit
    // real entries and duplicates pile up; the rest spans the full range.
    function automatic value_t pick_value();
        if ($urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return value_t'($urandom);
    endfunction

    initial
    begin
        int         phase;
        int         roll;
        int         k;
        logic [2:0] code;

        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_INSERT;
        value       = '0;
        index       = '0;
        cycle_count = 0;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // queries on the empty list
        issue_request(REQ_READ, '0, '0);                 // out of range
        issue_request(REQ_REMOVE, 16'h0005, '0);         // not found
        issue_request(REQ_CONTAINS, '0, '0);             // absent
        issue_request(REQ_COUNT, '0, '0);                // zero matches
        // extremes and a duplicate, inserted out of order
        issue_request(REQ_INSERT, '1, '0);
        issue_request(REQ_INSERT, '0, '0);
        issue_request(REQ_INSERT, 16'h8000, '0);
        issue_request(REQ_INSERT, 16'h8000, '0);
        issue_request(REQ_INSERT, 16'h7FFF, '0);
        issue_request(REQ_COUNT, 16'h8000, '0);          // two matches
        issue_request(REQ_CONTAINS, '1, '0);             // present
        issue_request(REQ_CONTAINS, 16'h1234, '0);       // absent
        issue_request(REQ_READ, '0, 6'd0);
        issue_request(REQ_READ, '0, 6'd4);               // last entry
        issue_request(REQ_READ, '0, 6'd5);               // one past the end
        issue_request(REQ_READ, '0, '1);                 // top index
        issue_request(REQ_REMOVE, 16'h8000, '0);         // one of the duplicates
        issue_request(REQ_REMOVE, 16'h1234, '0);         // not found
        issue_request(REQ_SPARE_A, '1, '1);              // ignored
        issue_request(REQ_SPARE_B, 16'hA5A5, 6'd2);      // ignored
        issue_request(REQ_CLEAR, '1, '1);
        issue_request(REQ_READ, '0, '0);                 // empty again

        // ---- random ----
        for (k = 0; k < POOL_SIZE; k++)
            value_pool[k] = value_t'($urandom);

        // Open with a straight fill past capacity so that inserts into a
        // full list turn up early.
        for (k = 0; k < DEPTH + 4; k++)
            issue_request(REQ_INSERT, pick_value(), idx_t'($urandom));

        for (k = DEPTH + 4; k < NUM_RANDOM; k++)
        begin
            // new phase: fresh pool, sometimes seeded with the extremes
            if (k % PHASE_LEN == 0)
            begin
                for (int p = 0; p < POOL_SIZE; p++)
                begin
                    roll = $urandom_range(0, 7);
                    value_pool[p] = (roll == 0) ? '1 : (roll == 1) ? '0 : value_t'($urandom);
                end
            end
            phase = (k / PHASE_LEN) % 3;
            roll  = $urandom_range(0, 99);

            // fill phase leans on inserts, drain phase on removes,
            // mixed phase spreads over the queries and a rare clear
            case (phase)
                0:       code = (roll < 70) ? REQ_INSERT : (roll < 78) ? REQ_REMOVE :
                                (roll < 87) ? REQ_READ : (roll < 93) ? REQ_CONTAINS :
                                (roll < 98) ? REQ_COUNT : REQ_SPARE_A;
                1:       code = (roll < 30) ? REQ_INSERT : (roll < 50) ? REQ_REMOVE :
                                (roll < 68) ? REQ_READ : (roll < 82) ? REQ_CONTAINS :
                                (roll < 96) ? REQ_COUNT : (roll < 98) ? REQ_CLEAR :
                                REQ_SPARE_B;
                default: code = (roll < 15) ? REQ_INSERT : (roll < 65) ? REQ_REMOVE :
                                (roll < 78) ? REQ_READ : (roll < 88) ? REQ_CONTAINS :
                                (roll < 98) ? REQ_COUNT : (roll < 99) ? REQ_CLEAR :
                                REQ_SPARE_A;
            endcase

            // gaps in bursts, none in the closing stretch
            if (k < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 3));

            issue_request(code, pick_value(), idx_t'($urandom));
        end

        @(negedge clk);
        start <= 1'b0;

        // drain: every result in, then quiet before the verdict
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 4)
            @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
